// ===== rtl/fqi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqi_pkg
// Shared types, sizes and codes for the queue with positional insert.
// ----------------------------------------------------------------------------
package fqi_pkg;

  // Storage sizes
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the beats
  localparam int CMD_W   = 2;
  localparam int WORD_W  = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 2;
  localparam int OCNT_W  = 5;

  // Count holds 0..DEPTH; compares run at the wider of count and position
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Command codes; the spare code leaves the queue untouched
  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic [OCNT_W-1:0]        count_out;
  } out_beat_t;

  // Per-cell load select, at most one set in a cycle
  typedef struct packed {
    logic take_in;
    logic take_prev;
    logic take_next;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/fqi_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqi_cell
// One queue slot: loads the new word, its front neighbor or its back neighbor.
// ----------------------------------------------------------------------------
module fqi_cell (
  input  wire logic                              clk,
  input  wire fqi_pkg::cell_ctrl_t               ctrl,
  input  wire logic [fqi_pkg::DATA_WIDTH-1:0]    new_data,
  input  wire logic [fqi_pkg::DATA_WIDTH-1:0]    prev_data,
  input  wire logic [fqi_pkg::DATA_WIDTH-1:0]    next_data,
  output logic      [fqi_pkg::DATA_WIDTH-1:0]    data
);
  import fqi_pkg::*;

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Select the source for this slot, hold otherwise
  always_comb begin
    data_nxt = data_r;
    if (ctrl.take_in) begin
      data_nxt = new_data;
    end else if (ctrl.take_prev) begin
      data_nxt = prev_data;
    end else if (ctrl.take_next) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
`default_nettype wire

// ===== rtl/fifo_queue_with_indexed_insert_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_indexed_insert_top
// Bounded queue of signed words with enqueue, dequeue and positional insert.
// ----------------------------------------------------------------------------
//  channel  ports                       direction  beat
//  in       in_valid in_stall in_data   sink       cmd, value, position
//  out      out_valid out_stall out_data source    data_out, status, count_out
//
//  One command per cycle while not stalled: every slot cell picks hold or shift
//  in parallel from its index against position and count, so a command finishes
//  in its accept cycle and the output register shows its result the cycle after.
//  Reset clears the count and the output valid; slot contents are not reset.
//  A stalled result blocks the input only while the output register is full.
// ----------------------------------------------------------------------------
module fifo_queue_with_indexed_insert_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fqi_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fqi_pkg::out_beat_t      out_data
);
  import fqi_pkg::*;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  out_beat_t             out_r;
  out_beat_t             out_nxt;

  logic                  in_acc;
  logic                  is_place;
  logic                  full;
  logic                  empty;
  logic                  in_range;
  logic                  do_place;
  logic                  do_deq;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      tgt_pos;
  logic [CMP_W-1:0]      cnt_nxt_ext;
  logic [DATA_WIDTH-1:0] new_word;

  cell_ctrl_t            ctrl   [DEPTH];
  logic [DATA_WIDTH-1:0] slot_q [DEPTH];

  // Accept while the output register is free or being drained
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Decode the command against the current count
  assign cnt_ext  = CMP_W'(count_r);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign is_place = (in_data.cmd == CMD_ENQ) || (in_data.cmd == CMD_INS);
  assign tgt_pos  = (in_data.cmd == CMD_INS) ? CMP_W'(in_data.position) : cnt_ext;
  assign in_range = (tgt_pos <= cnt_ext);
  assign do_place = in_acc && is_place && !full && in_range;
  assign do_deq   = in_acc && (in_data.cmd == CMD_DEQ) && !empty;
  assign new_word = DATA_WIDTH'(unsigned'(in_data.value));

  // Build the row of slot cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);
    logic [DATA_WIDTH-1:0] prev_d;
    logic [DATA_WIDTH-1:0] next_d;

    assign ctrl[i].take_in   = do_place && (tgt_pos == IDX);
    assign ctrl[i].take_prev = do_place && (i > 0) && (IDX > tgt_pos) && (IDX <= cnt_ext);
    assign ctrl[i].take_next = do_deq && (i < DEPTH - 1);

    if (i == 0) begin : g_first
      assign prev_d = new_word;
    end else begin : g_mid_p
      assign prev_d = slot_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = slot_q[i];
    end else begin : g_mid_n
      assign next_d = slot_q[i+1];
    end

    fqi_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .new_data  (new_word),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (slot_q[i])
    );
  end

  // Advance the count
  always_comb begin
    count_nxt = count_r;
    if (do_place) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_deq) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign cnt_nxt_ext = CMP_W'(count_nxt);

  // Form the result beat
  always_comb begin
    out_nxt.data_out  = '0;
    out_nxt.status    = ST_OK;
    out_nxt.count_out = cnt_nxt_ext[OCNT_W-1:0];
    unique case (in_data.cmd)
      CMD_ENQ, CMD_INS: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else if (!in_range) begin
          out_nxt.status = ST_RANGE;
        end
      end
      CMD_DEQ: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.data_out = WORD_W'(slot_q[0]);
        end
      end
      default: begin
        out_nxt.status = ST_OK;
      end
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("count exceeds depth");

  a_deq_dec: assert property (@(posedge clk) disable iff (!rst_n)
    do_deq |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("dequeue did not drop the count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && is_place && full |=> (out_r.status == ST_FULL) && $stable(count_r))
    else $error("full queue accepted a word");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire

// ===== bench/fqi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqi_checker
// Watches both channels of the queue with positional insert. It keeps its own
// copy of the slots and the count, works out the result of every accepted
// command and compares each result beat, field by field, with the oldest one
// still outstanding. It reports mismatches and the number still awaited.
// ----------------------------------------------------------------------------
module fqi_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  fqi_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  fqi_pkg::out_beat_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import fqi_pkg::*;

  // Shadow of the queue: head in slot 0
  logic [DATA_WIDTH-1:0] slots [DEPTH];
  int                    fill;

  out_beat_t awaited_results [$];
  int        mismatches;

  initial begin
    fill       = 0;
    mismatches = 0;
    fail_count = 0;
    pending    = 0;
  end

  // Put a word at pos and move the later entries back
  function automatic logic [STAT_W-1:0] place_word(logic signed [WORD_W-1:0] v, int pos);
    if (fill >= DEPTH) return ST_FULL;
    if (pos > fill) return ST_RANGE;
    for (int k = fill; k > pos; k--) slots[k] = slots[k-1];
    slots[pos] = DATA_WIDTH'(v);
    fill++;
    return ST_OK;
  endfunction

  // Apply one command to the shadow and return the beat it should produce
  function automatic out_beat_t queue_result(in_beat_t c);
    out_beat_t r;
    r.data_out = '0;
    r.status   = ST_OK;
    case (c.cmd)
      CMD_ENQ: begin
        r.status = place_word(c.value, fill);
      end
      CMD_DEQ: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = WORD_W'(slots[0]);
          for (int k = 1; k < fill; k++) slots[k-1] = slots[k];
          fill--;
        end
      end
      CMD_INS: begin
        r.status = place_word(c.value, int'(c.position));
      end
      default: begin
      end
    endcase
    r.count_out = OCNT_W'(fill);
    return r;
  endfunction

  // Compare result beats first, then predict from the command beat
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      fill = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t unexpected result beat: data %0d status %0d count %0d",
                     $realtime, out_data.data_out, out_data.status, out_data.count_out);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.data_out !== want.data_out || out_data.status !== want.status ||
              out_data.count_out !== want.count_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch: want data %0d status %0d count %0d, got %0d %0d %0d",
                       $realtime, want.data_out, want.status, want.count_out,
                       out_data.data_out, out_data.status, out_data.count_out);
          end
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(queue_result(in_data));
    end
    fail_count <= mismatches;
    pending    <= awaited_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the queue with positional insert: a directed opening over the empty,
// full and out-of-range cases, then random command mixes that sweep the fill
// level up and down. Both sides idle at random, the receiver holds off once
// long enough to back the block up. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import fqi_pkg::*;

  localparam int RANDOM_ITEMS = 1275;
  localparam int QUIET_LO     = 1500;
  localparam int QUIET_HI     = 1900;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_LEN     = 250;
  localparam int DRAIN_TAIL   = 16;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_beat_t out_data;
  int        fail_count;
  int        pending;
  int        cyc = 0;

  fifo_queue_with_indexed_insert_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  fqi_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  // Random gap decision, suppressed inside the quiet window
  function automatic bit take_gap();
    if (cyc >= QUIET_LO && cyc < QUIET_HI) return 1'b0;
    return $urandom_range(0, 99) < 24;
  endfunction

  // Offer one command beat and hold it until accepted; call at a falling edge
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] v,
                          input logic [POS_W-1:0] p);
    in_beat_t b;
    b.cmd      = c;
    b.value    = v;
    b.position = p;
    while (take_gap()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Receiver: random stall, one long hold-off, quiet window
  initial begin
    forever begin
      @(negedge clk);
      if (cyc == HOLD_AT) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        out_stall <= take_gap();
      end
    end
  end

  // Run limit
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [WORD_W-1:0] word;
    logic [CMD_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    bit                filling;
    int                r;

    // Hold reset, then release it on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue, out-of-range insert, insert on empty
    send_cmd(CMD_DEQ, 32'h0000_0000, 5'd0);
    send_cmd(CMD_INS, 32'h1234_5678, 5'd1);
    send_cmd(CMD_INS, 32'h8000_0000, 5'd0);
    send_cmd(CMD_ENQ, 32'h7FFF_FFFF, 5'd31);
    // Insert at count acts as enqueue, then in the middle
    send_cmd(CMD_INS, 32'hFFFF_FFFF, 5'd2);
    send_cmd(CMD_INS, 32'h0000_0000, 5'd1);
    // Unused code, then far out of range
    send_cmd(CMD_NOP, 32'hDEAD_BEEF, 5'd31);
    send_cmd(CMD_INS, 32'h5555_5555, 5'd31);
    send_cmd(CMD_DEQ, 32'hAAAA_AAAA, 5'd16);
    // Fill up, then hit the full cases; full wins over range
    repeat (DEPTH - 3) send_cmd(CMD_ENQ, $urandom, 5'($urandom_range(0, 31)));
    send_cmd(CMD_ENQ, 32'h0BAD_F00D, 5'd0);
    send_cmd(CMD_INS, 32'h7FFF_FFFF, 5'd0);
    send_cmd(CMD_INS, 32'h8000_0000, 5'd31);

    // Random mixes alternating between filling and draining
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 39) == 0) filling = ~filling;
      r = $urandom_range(0, 99);
      if (r < 3)                         op = CMD_NOP;
      else if (r < (filling ? 48 : 23))  op = CMD_ENQ;
      else if (r < (filling ? 83 : 38))  op = CMD_INS;
      else                               op = CMD_DEQ;
      case ($urandom_range(0, 19))
        0:       word = 32'h8000_0000;
        1:       word = 32'h7FFF_FFFF;
        2:       word = 32'h0000_0000;
        3:       word = 32'hFFFF_FFFF;
        default: word = $urandom;
      endcase
      if ($urandom_range(0, 4) == 0) pos = 5'($urandom_range(0, 31));
      else                           pos = 5'($urandom_range(0, DEPTH));
      send_cmd(op, word, pos);
    end
    in_valid <= 1'b0;

    // Drain and settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fqi_pkg.sv
rtl/fqi_cell.sv
rtl/fifo_queue_with_indexed_insert_top.sv
bench/fqi_checker.sv
bench/tb.sv
